[design/adc_scan_oversample_average_core_macros.svh]
// Assertion macros for the ADC scan oversampling core.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ADC_SCAN_OVERSAMPLE_AVERAGE_CORE_MACROS_SVH
`define ADC_SCAN_OVERSAMPLE_AVERAGE_CORE_MACROS_SVH

// Check that is off while reset is asserted.
`define ASOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds through reset.
`define ASOA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/asoa_pkg.sv]
// Shared types and constants for the ADC scan oversampling core.
// No dependencies; used by asoa_avg_store and the top level.
package asoa_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int CHAN_W       = 3;
  localparam int MUX_W        = 5;
  localparam int NUM_CH_W     = 4;
  localparam int MUX_ENTRIES  = 8;
  localparam int MUX_CODES_W  = MUX_W * MUX_ENTRIES;
  localparam int CFG_DATA_W   = MUX_CODES_W;
  localparam int CFG_IDX_W    = 1;

  localparam int CHANNELS_DEF  = 8;
  localparam int AVG_SHIFT_DEF = 4;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS = 1'b0,
    REG_MUX_CODES    = 1'b1
  } reg_idx_t;

  // Write request into the average store.
  typedef struct packed {
    logic                wr_en;
    logic [CHAN_W-1:0]   wr_chan;
    logic [SAMPLE_W-1:0] wr_avg;
  } avg_wr_t;

endpackage

[design/asoa_avg_store.sv]
// Per-channel average storage: one write port, one read port.
// Depends on asoa_pkg.
module asoa_avg_store #(
  parameter int CHANNELS = asoa_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  asoa_pkg::avg_wr_t                wr,
  input  logic [asoa_pkg::CHAN_W-1:0]      rd_chan,
  output logic [asoa_pkg::SAMPLE_W-1:0]    rd_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [asoa_pkg::NUM_CH_W-1:0] CHAN_LIMIT = asoa_pkg::NUM_CH_W'(CHANNELS);

  logic [asoa_pkg::SAMPLE_W-1:0] avg_r [CHANNELS];

  logic wr_ok;
  logic rd_ok;

  assign wr_ok = wr.wr_en && ({1'b0, wr.wr_chan} < CHAN_LIMIT);
  assign rd_ok = {1'b0, rd_chan} < CHAN_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        avg_r[i] <= '0;
      end
    end else if (wr_ok) begin
      avg_r[wr.wr_chan[IDX_W-1:0]] <= wr.wr_avg;
    end
  end

  // Channels at or above CHANNELS read as zero.
  assign rd_data = rd_ok ? avg_r[rd_chan[IDX_W-1:0]] : '0;

endmodule

[design/adc_scan_oversample_average_core.sv]
// Channel      | Signals                                          | Direction
// input item   | in_valid/in_ready, in_opcode, in_sample,         | in
//              | in_read_channel                                  |
// result item  | out_valid/out_ready, out_read_value, out_mux_code,| out
//              | out_stored, out_stored_channel                   |
// config write | cfg_valid/cfg_ready, cfg_index, cfg_data         | in
//
// One item per cycle while in_ready is high; each result is registered and appears in the cycle after its transfer.
// Path per item: one accumulator add of 10+AVG_SHIFT bits and a channel-count compare.
// in_ready is low only while the result register is full and out_ready is low.
// Synchronous reset clears the accumulator, count, scan index and all averages
// at once; no clearing pass. cfg_ready is always high.
// Depends on asoa_pkg, asoa_avg_store and the assertion macro header.
`include "adc_scan_oversample_average_core_macros.svh"

module adc_scan_oversample_average_core #(
  parameter int CHANNELS  = asoa_pkg::CHANNELS_DEF,
  parameter int AVG_SHIFT = asoa_pkg::AVG_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [asoa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asoa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [asoa_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [asoa_pkg::CHAN_W-1:0]       in_read_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [asoa_pkg::SAMPLE_W-1:0]     out_read_value,
  output logic [asoa_pkg::MUX_W-1:0]        out_mux_code,
  output logic                              out_stored,
  output logic [asoa_pkg::CHAN_W-1:0]       out_stored_channel
);

  localparam int SUM_W = asoa_pkg::SAMPLE_W + AVG_SHIFT;
  localparam int CNT_W = AVG_SHIFT + 1;
  localparam logic [asoa_pkg::NUM_CH_W-1:0] CHAN_LIMIT = asoa_pkg::NUM_CH_W'(CHANNELS);

  logic [asoa_pkg::NUM_CH_W-1:0]    num_channels_r;
  logic [asoa_pkg::MUX_CODES_W-1:0] mux_codes_r;

  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [asoa_pkg::CHAN_W-1:0]   active_r, active_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [asoa_pkg::SAMPLE_W-1:0] read_value_r, read_value_nxt;
  logic [asoa_pkg::MUX_W-1:0]    mux_code_r, mux_code_nxt;
  logic                          stored_r, stored_nxt;
  logic [asoa_pkg::CHAN_W-1:0]   stored_chan_r, stored_chan_nxt;

  logic                          in_fire;
  logic                          cfg_fire;
  logic [asoa_pkg::NUM_CH_W-1:0] eff_count;
  logic [asoa_pkg::NUM_CH_W-1:0] active_inc;
  logic [asoa_pkg::SAMPLE_W-1:0] store_rd;
  asoa_pkg::avg_wr_t             avg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_channels_r <= asoa_pkg::NUM_CH_W'(1);
      mux_codes_r    <= '0;
    end else if (cfg_fire) begin
      unique case (asoa_pkg::reg_idx_t'(cfg_index))
        asoa_pkg::REG_NUM_CHANNELS: num_channels_r <= cfg_data[asoa_pkg::NUM_CH_W-1:0];
        asoa_pkg::REG_MUX_CODES:    mux_codes_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the list length to 1..CHANNELS.
  always_comb begin
    priority if (num_channels_r == '0) begin
      eff_count = asoa_pkg::NUM_CH_W'(1);
    end else if (num_channels_r > CHAN_LIMIT) begin
      eff_count = CHAN_LIMIT;
    end else begin
      eff_count = num_channels_r;
    end
  end

  assign active_inc = {1'b0, active_r} + asoa_pkg::NUM_CH_W'(1);

  asoa_avg_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (avg_wr),
    .rd_chan (in_read_channel),
    .rd_data (store_rd)
  );

  always_comb begin
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    active_nxt      = active_r;
    read_value_nxt  = '0;
    stored_nxt      = 1'b0;
    stored_chan_nxt = '0;
    avg_wr.wr_en    = 1'b0;
    avg_wr.wr_chan  = active_r;
    avg_wr.wr_avg   = sum_r[SUM_W-1:AVG_SHIFT];
    if (in_fire) begin
      unique case (asoa_pkg::op_t'(in_opcode))
        asoa_pkg::OP_READ: begin
          read_value_nxt = store_rd;
        end
        asoa_pkg::OP_SAMPLE: begin
          if (!count_r[AVG_SHIFT]) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(in_sample);
          end else begin
            // Window full: drop this sample, store the average, advance the scan.
            avg_wr.wr_en    = 1'b1;
            sum_nxt         = '0;
            count_nxt       = '0;
            stored_nxt      = 1'b1;
            stored_chan_nxt = active_r;
            active_nxt      = (active_inc < eff_count) ?
                              active_inc[asoa_pkg::CHAN_W-1:0] : '0;
          end
        end
        default: ;
      endcase
    end
    mux_code_nxt = mux_codes_r[asoa_pkg::MUX_W*active_nxt +: asoa_pkg::MUX_W];
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload; load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_value_r  <= read_value_nxt;
      mux_code_r    <= mux_code_nxt;
      stored_r      <= stored_nxt;
      stored_chan_r <= stored_chan_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = read_value_r;
  assign out_mux_code       = mux_code_r;
  assign out_stored         = stored_r;
  assign out_stored_channel = stored_chan_r;

  `ASOA_ASSERT(a_count_bound, count_r <= CNT_W'(1 << AVG_SHIFT), "sample count past window")
  `ASOA_ASSERT(a_active_bound, {1'b0, active_r} < CHAN_LIMIT, "scan index outside store")
  `ASOA_ASSERT(a_store_clears, in_fire && !in_opcode && count_r[AVG_SHIFT] |=> count_r == '0 && sum_r == '0 && out_stored, "store did not clear window")
  `ASOA_ASSERT(a_read_keeps_state, in_fire && in_opcode |=> $stable(sum_r) && $stable(count_r) && $stable(active_r), "read item changed scan state")
  `ASOA_ASSERT(a_store_no_read, out_valid_r && out_stored |-> out_read_value == '0, "store result carries read data")

endmodule

[sim/adc_scan_oversample_average_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for adc_scan_oversample_average_core: directed, backpressure
// and random traffic against a cycle-free scan/average predictor. Needs asoa_pkg and the RTL.
module adc_scan_oversample_average_core_tb;

  localparam int SAMPLE_W    = asoa_pkg::SAMPLE_W;
  localparam int CHAN_W      = asoa_pkg::CHAN_W;
  localparam int MUX_W       = asoa_pkg::MUX_W;
  localparam int NUM_CH_W    = asoa_pkg::NUM_CH_W;
  localparam int MUX_CODES_W = asoa_pkg::MUX_CODES_W;
  localparam int CFG_DATA_W  = asoa_pkg::CFG_DATA_W;
  localparam int CFG_IDX_W   = asoa_pkg::CFG_IDX_W;

  localparam int N_CH           = asoa_pkg::CHANNELS_DEF;
  localparam int SHIFT          = asoa_pkg::AVG_SHIFT_DEF;
  localparam int WINDOW         = (1 << SHIFT) + 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_value;
    logic [MUX_W-1:0]    mux_code;
    logic                stored;
    logic [CHAN_W-1:0]   stored_channel;
  } scan_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = 1'b0;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic [CHAN_W-1:0]      in_read_channel = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_W-1:0]    out_read_value;
  logic [MUX_W-1:0]       out_mux_code;
  logic                   out_stored;
  logic [CHAN_W-1:0]      out_stored_channel;

  // Predictor state
  int                     acc_sum;
  int                     acc_count;
  int                     scan_chan;
  logic [SAMPLE_W-1:0]    avg_store [N_CH];
  logic [NUM_CH_W-1:0]    cfg_num_ch;
  logic [MUX_CODES_W-1:0] cfg_mux_codes;

  scan_result_t           expected_results [$];
  int                     fail_count = 0;
  bit                     idle_on = 1'b1;
  bit                     long_hold_req = 1'b0;
  int                     hold_left = 0;
  int                     quiet_cycles = 0;

  adc_scan_oversample_average_core #(
    .CHANNELS  (N_CH),
    .AVG_SHIFT (SHIFT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_sample          (in_sample),
    .in_read_channel    (in_read_channel),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_value     (out_read_value),
    .out_mux_code       (out_mux_code),
    .out_stored         (out_stored),
    .out_stored_channel (out_stored_channel)
  );

  always #10 clk = ~clk;

  function automatic void reset_scan_model();
    acc_sum       = 0;
    acc_count     = 0;
    scan_chan     = 0;
    cfg_num_ch    = 4'd1;
    cfg_mux_codes = '0;
    for (int i = 0; i < N_CH; i++) avg_store[i] = '0;
  endfunction

  // Advance the scan/average state by one item and return its result.
  function automatic scan_result_t predict_scan(asoa_pkg::op_t op, logic [SAMPLE_W-1:0] smp,
                                                logic [CHAN_W-1:0] rch);
    scan_result_t r;
    int           n;
    r = '0;
    if (op == asoa_pkg::OP_READ) begin
      r.read_value = avg_store[rch];
    end else if (acc_count < (1 << SHIFT)) begin
      acc_count++;
      acc_sum += smp;
    end else begin
      avg_store[scan_chan] = SAMPLE_W'(acc_sum >> SHIFT);
      acc_sum          = 0;
      acc_count        = 0;
      r.stored         = 1'b1;
      r.stored_channel = CHAN_W'(scan_chan);
      n = cfg_num_ch;
      if (n < 1) n = 1;
      if (n > N_CH) n = N_CH;
      scan_chan = (scan_chan + 1 < n) ? scan_chan + 1 : 0;
    end
    r.mux_code = cfg_mux_codes[MUX_W*scan_chan +: MUX_W];
    return r;
  endfunction

  // Leaves in_valid high so back-to-back items stream without a bubble, unless idle_on inserts a random gap first.
  task automatic send_item(asoa_pkg::op_t op, logic [SAMPLE_W-1:0] smp,
                           logic [CHAN_W-1:0] rch);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample       <= smp;
    in_read_channel <= rch;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_scan(op, smp, rch));
  endtask

  // Stop offering and hold until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_scan_config(logic [NUM_CH_W-1:0] num, logic [MUX_CODES_W-1:0] codes);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    cfg_valid <= 1'b1;
    cfg_index <= asoa_pkg::REG_NUM_CHANNELS;
    cfg_data  <= {junk[CFG_DATA_W-1:NUM_CH_W], num};
    do @(posedge clk); while (!cfg_ready);
    cfg_num_ch = num;
    cfg_index <= asoa_pkg::REG_MUX_CODES;
    cfg_data  <= codes;
    do @(posedge clk); while (!cfg_ready);
    cfg_mux_codes = codes;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_random(int count, int read_pct);
    asoa_pkg::op_t op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < read_pct) ? asoa_pkg::OP_READ : asoa_pkg::OP_SAMPLE;
      send_item(op, pick_sample(), CHAN_W'($urandom_range(0, 7)));
    end
  endtask

  function automatic logic [MUX_CODES_W-1:0] random_codes();
    return MUX_CODES_W'({$urandom, $urandom});
  endfunction

  task automatic test_read_after_reset();
    for (int ch = 0; ch < N_CH; ch++) send_item(asoa_pkg::OP_READ, '0, CHAN_W'(ch));
    drain_results();
  endtask

  // Full-scale window on channel 0, then the dropped sample stores it.
  task automatic test_full_scale_window();
    write_scan_config(4'd2, '1);
    for (int i = 0; i < (1 << SHIFT); i++) send_item(asoa_pkg::OP_SAMPLE, '1, 3'd7);
    send_item(asoa_pkg::OP_SAMPLE, '0, 3'd0);
    send_item(asoa_pkg::OP_READ, '1, 3'd0);
    drain_results();
  endtask

  task automatic test_channel_count_zero();
    write_scan_config(4'd0, random_codes());
    send_random(3 * WINDOW + 6, 10);
    drain_results();
  endtask

  task automatic test_channel_count_saturate();
    write_scan_config(4'd15, random_codes());
    send_random(9 * WINDOW, 0);
    for (int ch = 0; ch < N_CH; ch++) send_item(asoa_pkg::OP_READ, pick_sample(), CHAN_W'(ch));
    drain_results();
  endtask

  // Park the scan on channel 5, then shrink the list under it.
  task automatic test_count_lowered_midscan();
    write_scan_config(4'd8, random_codes());
    while (scan_chan != 5) send_item(asoa_pkg::OP_SAMPLE, pick_sample(), '0);
    drain_results();
    write_scan_config(4'd2, random_codes());
    send_random(3 * WINDOW, 0);
    send_item(asoa_pkg::OP_READ, '0, 3'd5);
    drain_results();
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    send_random(40, 20);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [NUM_CH_W-1:0] nums [6];
    nums = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd6};
    for (int p = 0; p < 6; p++) begin
      write_scan_config(nums[p], (p == 1) ? '0 : random_codes());
      if (p == 5) idle_on = 1'b0;
      send_random(75, 15);
      drain_results();
    end
  endtask

  // Result side: random stall bursts plus one long hold on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_value %0d mux_code %0d stored %0d stored_channel %0d",
               out_read_value, out_mux_code, out_stored, out_stored_channel);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, out_read_value);
          fail_count++;
        end
        if (out_mux_code !== want.mux_code) begin
          $error("mux_code: expected %0d, actual %0d", want.mux_code, out_mux_code);
          fail_count++;
        end
        if (out_stored !== want.stored) begin
          $error("stored: expected %0d, actual %0d", want.stored, out_stored);
          fail_count++;
        end
        if (out_stored_channel !== want.stored_channel) begin
          $error("stored_channel: expected %0d, actual %0d", want.stored_channel,
                 out_stored_channel);
          fail_count++;
        end
      end
    end
  end

  // Abort if no transfer on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_scan_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_read_after_reset();
    test_full_scale_window();
    test_channel_count_zero();
    test_channel_count_saturate();
    test_count_lowered_midscan();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
